/* sv/vin_check_digit_validator_unit_assert.svh */
// ----------------------------------------------------------------------------
// VIN check-digit validator: assertion macros
// Shared property macros, sampled on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VIN_CHECK_DIGIT_VALIDATOR_UNIT_ASSERT_SVH
`define VIN_CHECK_DIGIT_VALIDATOR_UNIT_ASSERT_SVH

// Same-cycle implication
`define VCDV_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define VCDV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/vcdv_pkg.sv */
// ----------------------------------------------------------------------------
// VIN check-digit validator package
// Beat and result types, weight and transliteration tables, status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vcdv_pkg;

    localparam int VIN_LENGTH   = 17;
    localparam int CHECK_POS    = 8;
    localparam int POS_SATURATE = 18;
    localparam int POS_W        = 5;
    localparam int SUM_W        = 10;
    localparam int PROD_W       = 7;
    localparam int NUM_LETTERS  = 26;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // sum / 11 by reciprocal: floor(sum * 93 / 1024) is floor(sum/11) or one less
    localparam int MOD_RECIP = 93;
    localparam int MOD_SHIFT = 10;
    localparam int MODULUS   = 11;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_X    = 8'h58;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_LEN  = 2'd1;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd2;
    localparam logic [1:0] STATUS_MISMATCH = 2'd3;

    localparam logic [3:0] POS_WEIGHT [VIN_LENGTH] =
        '{4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd10, 4'd0,
          4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2};

    localparam logic [3:0] LETTER_VALUE [NUM_LETTERS] =
        '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9,
          4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9,
          4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9};

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic       is_valid;
        logic [1:0] status_code;
    } t_out_item;

    // One classified character
    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic              bad;
        logic              chk;
        logic [7:0]        chr;
        logic              last;
        logic              len_ok;
    } t_beat;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

`default_nettype wire

/* sv/vin_check_digit_validator_unit.sv */
// ----------------------------------------------------------------------------
// VIN check-digit validator
// Mod-11 check of a 17-character identification string, one byte a beat.
//
//   Channel  Direction  Handshake              Payload
//   input    in         push / full            i_item   (char_code, end_of_string)
//   result   out        empty / pop            o_result (is_valid, status_code)
//
// One character beat is taken every cycle while full is low; the front
// classifies it in the cycle it arrives and the back accumulates it
// after it has passed through a four-beat queue.
// After its last beat is taken, a string's result is carried through the
// queue, the finish register and the result register.
// Reset clears the position, the sums and all valid flags.
// A held result stalls the back once the finish register is also full;
// the front keeps taking beats until the queue fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "vin_check_digit_validator_unit_assert.svh"

module vin_check_digit_validator_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire vcdv_pkg::t_in_item i_item,
    output logic                    empty,
    input  wire logic               pop,
    output vcdv_pkg::t_out_item     o_result
);

    logic               w_q_wr, w_q_rd;
    vcdv_pkg::t_beat    w_wr_beat, w_rd_beat;
    vcdv_pkg::t_qstat   w_qstat;

    assign full = w_qstat.full;

    // Classify incoming characters
    vcdv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .i_qstat (w_qstat),
        .o_wr    (w_q_wr),
        .o_beat  (w_wr_beat)
    );

    // Decouple front and back
    vcdv_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_q_wr),
        .i_wr_data (w_wr_beat),
        .i_rd      (w_q_rd),
        .o_rd_data (w_rd_beat),
        .o_stat    (w_qstat)
    );

    // Accumulate and report
    vcdv_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qstat  (w_qstat),
        .i_beat   (w_rd_beat),
        .o_rd     (w_q_rd),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // Checks
    `VCDV_ASSERT_NEXT(a_push_lands, push && !full, !w_qstat.empty, "accepted beat missing from queue")
    `VCDV_ASSERT_IMPLY(a_rd_nonempty, w_q_rd, !w_qstat.empty, "back read an empty queue")
    `VCDV_ASSERT_IMPLY(a_wr_room, w_q_wr, !w_qstat.full, "front wrote a full queue")
    `VCDV_ASSERT_IMPLY(a_valid_status, !empty, o_result.is_valid == (o_result.status_code == vcdv_pkg::STATUS_OK), "is_valid disagrees with status")

endmodule

`default_nettype wire

/* sv/vcdv_queue.sv */
// ----------------------------------------------------------------------------
// VIN check-digit validator: beat queue
// Small FIFO of classified beats between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vcdv_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire vcdv_pkg::t_beat i_wr_data,
    input  wire logic           i_rd,
    output vcdv_pkg::t_beat     o_rd_data,
    output vcdv_pkg::t_qstat    o_stat
);

    vcdv_pkg::t_beat                   r_mem [vcdv_pkg::QUEUE_DEPTH];
    logic [vcdv_pkg::QUEUE_AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [vcdv_pkg::QUEUE_AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [vcdv_pkg::QUEUE_CW-1:0]     r_count, n_count;
    logic                              w_wr_en, w_rd_en;

    // Qualify the moves against the fill level
    assign w_wr_en = i_wr && (r_count != vcdv_pkg::QUEUE_CW'(vcdv_pkg::QUEUE_DEPTH));
    assign w_rd_en = i_rd && (r_count != '0);

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr_en) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (w_rd_en) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (w_wr_en && !w_rd_en) begin
            n_count = r_count + 1'b1;
        end else if (!w_wr_en && w_rd_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming beat
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_rd_data    = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == vcdv_pkg::QUEUE_CW'(vcdv_pkg::QUEUE_DEPTH));

endmodule

`default_nettype wire

/* sv/vcdv_front.sv */
// ----------------------------------------------------------------------------
// VIN check-digit validator: front end
// Tracks the character position, classifies each byte and forms its
// weighted value, and writes one beat per accepted character to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vcdv_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire vcdv_pkg::t_in_item i_item,
    input  wire vcdv_pkg::t_qstat   i_qstat,
    output logic                    o_wr,
    output vcdv_pkg::t_beat         o_beat
);

    logic [vcdv_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]                 w_chr, w_upper;
    logic                       w_digit, w_lower, w_letter, w_excluded, w_ok;
    logic                       w_in_range;
    logic [4:0]                 w_idx;
    logic [3:0]                 w_value, w_weight;
    logic [7:0]                 w_prod;

    assign o_wr  = i_push && !i_qstat.full;
    assign w_chr = i_item.char_code;

    // Classify the byte
    always_comb begin
        w_digit    = (w_chr inside {[8'h30:8'h39]});
        w_lower    = (w_chr inside {[8'h61:8'h7A]});
        w_upper    = w_lower ? (w_chr & 8'hDF) : w_chr;
        w_letter   = (w_upper inside {[8'h41:8'h5A]});
        w_excluded = (w_upper inside {8'h49, 8'h4F, 8'h51});
        w_ok       = w_digit || (w_letter && !w_excluded);
        w_idx      = w_upper[4:0] - 5'd1;
        if (w_digit) begin
            w_value = w_chr[3:0];
        end else if (w_letter && (w_idx < 5'(vcdv_pkg::NUM_LETTERS))) begin
            w_value = vcdv_pkg::LETTER_VALUE[w_idx];
        end else begin
            w_value = 4'd0;
        end
    end

    // Look up the position weight and form the product
    always_comb begin
        w_in_range = (r_pos < vcdv_pkg::POS_W'(vcdv_pkg::VIN_LENGTH));
        w_weight   = w_in_range ? vcdv_pkg::POS_WEIGHT[r_pos] : 4'd0;
        w_prod     = (w_in_range && w_ok) ? (8'(w_value) * 8'(w_weight)) : 8'd0;
    end

    // Build the beat
    always_comb begin
        o_beat.prod   = w_prod[vcdv_pkg::PROD_W-1:0];
        o_beat.bad    = w_in_range && !w_ok;
        o_beat.chk    = (r_pos == vcdv_pkg::POS_W'(vcdv_pkg::CHECK_POS));
        o_beat.chr    = w_chr;
        o_beat.last   = i_item.end_of_string;
        o_beat.len_ok = (r_pos == vcdv_pkg::POS_W'(vcdv_pkg::VIN_LENGTH - 1));
    end

    // Advance the position, saturating, and restart after the last character
    always_comb begin
        n_pos = r_pos;
        if (o_wr) begin
            if (i_item.end_of_string) begin
                n_pos = '0;
            end else if (r_pos < vcdv_pkg::POS_W'(vcdv_pkg::POS_SATURATE)) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

`default_nettype wire

/* sv/vcdv_back.sv */
// ----------------------------------------------------------------------------
// VIN check-digit validator: back end
// Accumulates weighted values, latches the finished string, reduces the
// sum mod 11 and holds the result until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vcdv_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire vcdv_pkg::t_qstat   i_qstat,
    input  wire vcdv_pkg::t_beat    i_beat,
    output logic                    o_rd,
    output logic                    empty,
    input  wire logic               pop,
    output vcdv_pkg::t_out_item     o_result
);

    logic [vcdv_pkg::SUM_W-1:0] r_sum, n_sum;
    logic                       r_bad, n_bad;
    logic [7:0]                 r_chk, n_chk;

    logic                       r_fin_valid;
    logic [vcdv_pkg::SUM_W-1:0] r_fin_sum;
    logic                       r_fin_bad;
    logic [7:0]                 r_fin_chk;
    logic                       r_fin_len_ok;

    logic                       r_out_valid;
    vcdv_pkg::t_out_item        r_out;

    logic                       w_out_free, w_fin_free;
    logic [16:0]                w_mul;
    logic [6:0]                 w_quot;
    logic [vcdv_pkg::SUM_W-1:0] w_quot11, w_diff;
    logic [4:0]                 w_rem_raw;
    logic [3:0]                 w_rem;
    logic [7:0]                 w_expect;
    logic [1:0]                 w_status;

    // Stall control from the result side back to the queue
    assign w_out_free = !r_out_valid || pop;
    assign w_fin_free = !r_fin_valid || w_out_free;
    assign o_rd       = !i_qstat.empty && w_fin_free;

    // Accumulate the string
    always_comb begin
        n_sum = r_sum + vcdv_pkg::SUM_W'(i_beat.prod);
        n_bad = r_bad || i_beat.bad;
        n_chk = i_beat.chk ? i_beat.chr : r_chk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_bad <= 1'b0;
            r_chk <= '0;
        end else if (o_rd) begin
            if (i_beat.last) begin
                r_sum <= '0;
                r_bad <= 1'b0;
                r_chk <= '0;
            end else begin
                r_sum <= n_sum;
                r_bad <= n_bad;
                r_chk <= n_chk;
            end
        end
    end

    // Latch the finished string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (o_rd && i_beat.last) begin
            r_fin_valid <= 1'b1;
        end else if (r_fin_valid && w_out_free) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rd && i_beat.last) begin
            r_fin_sum    <= n_sum;
            r_fin_bad    <= n_bad;
            r_fin_chk    <= n_chk;
            r_fin_len_ok <= i_beat.len_ok;
        end
    end

    // Reduce mod 11 by reciprocal, then correct once
    always_comb begin
        w_mul     = 17'(r_fin_sum) * 17'(vcdv_pkg::MOD_RECIP);
        w_quot    = w_mul[16:vcdv_pkg::MOD_SHIFT];
        w_quot11  = {w_quot, 3'b000} + {1'b0, w_quot, 2'b00} - vcdv_pkg::SUM_W'(w_quot);
        w_diff    = r_fin_sum - w_quot11;
        w_rem_raw = w_diff[4:0];
        if (w_rem_raw >= 5'(vcdv_pkg::MODULUS)) begin
            w_rem = 4'(w_rem_raw - 5'(vcdv_pkg::MODULUS));
        end else begin
            w_rem = w_rem_raw[3:0];
        end
        w_expect = (w_rem == 4'd10) ? vcdv_pkg::ASCII_X : (vcdv_pkg::ASCII_ZERO + 8'(w_rem));
    end

    // Pick the status: length, then character, then check digit
    always_comb begin
        if (!r_fin_len_ok) begin
            w_status = vcdv_pkg::STATUS_BAD_LEN;
        end else if (r_fin_bad) begin
            w_status = vcdv_pkg::STATUS_BAD_CHAR;
        end else if (r_fin_chk != w_expect) begin
            w_status = vcdv_pkg::STATUS_MISMATCH;
        end else begin
            w_status = vcdv_pkg::STATUS_OK;
        end
    end

    // Hold the result until popped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_fin_valid && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fin_valid && w_out_free) begin
            r_out.is_valid    <= (w_status == vcdv_pkg::STATUS_OK);
            r_out.status_code <= w_status;
        end
    end

    assign empty    = !r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire
